@@ rtl/ohs_pkg.sv @@
package ohs_pkg;

  // Default geometry of the history stack.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int FUNC_W    = 2;
  localparam int CFG_LEN_W = 5;

  // Operation codes carried on the func field.
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // shift toward the old end, cell 0 takes the new entry
    logic pop;    // shift toward the new end
    logic flush;  // mark every cell empty
  } ohs_ctrl_t;

endpackage

@@ rtl/ohs_cell.sv @@
module ohs_cell
  import ohs_pkg::*;
#(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ohs_ctrl_t              ctrl,
  input  logic                   in_ring,
  input  logic                   prev_valid,
  input  logic [ENTRY_WIDTH-1:0] prev_data,
  input  logic                   next_valid,
  input  logic [ENTRY_WIDTH-1:0] next_data,
  output logic                   valid,
  output logic [ENTRY_WIDTH-1:0] data
);

  logic                   valid_r;
  logic                   valid_nxt;
  logic [ENTRY_WIDTH-1:0] data_r;
  logic [ENTRY_WIDTH-1:0] data_nxt;

  // A cell past the configured ring length never becomes valid, which is how
  // a push into a full ring drops the oldest entry.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.flush) begin
      valid_nxt = 1'b0;
    end else if (ctrl.push) begin
      valid_nxt = prev_valid & in_ring;
      data_nxt  = prev_data;
    end else if (ctrl.pop) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

@@ rtl/overwriting_history_stack_top.sv @@
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------
// input     | in_valid / in_stall    | in_func, in_push_value
// result    | out_valid / out_stall  | out_ok, out_read_value, out_now_empty
// config    | cfg_wr_en              | cfg_wr_data (ring length)
//
// Every accepted beat updates the cell chain, and its result beat appears on
// the next cycle from the single output register, so one beat per cycle is
// sustained while the result side does not stall.
// Reset (rst_n low at a clock edge) empties the stack and sets the ring
// length to MAX_ENTRIES.
// A result beat that is stalled holds the output register, and a new input
// beat is taken only when that register is free or drains in the same cycle.
module overwriting_history_stack_top
  import ohs_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [ENTRY_WIDTH-1:0] in_push_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic [ENTRY_WIDTH-1:0] out_read_value,
  output logic                   out_now_empty,
  input  logic                   cfg_wr_en,
  input  logic [CFG_LEN_W-1:0]   cfg_wr_data
);

  // The length register must hold MAX_ENTRIES itself; comparisons against
  // the 5-bit configuration value are done in the wider of the two widths.
  localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

  // The stack is a row of cells. Cell 0 holds the newest entry and deeper
  // cells hold older ones. A push shifts the whole row one place deeper, a
  // pop shifts it one place back. Valid bits always form a solid run from
  // cell 0, so the run length is the number of entries in use.
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       len_nxt;
  logic [CMP_W-1:0]       cfg_ext;
  logic [MAX_ENTRIES-1:0] in_ring;
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [ENTRY_WIDTH-1:0] cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]   valid_ext;
  ohs_ctrl_t              ctrl;
  logic                   in_fire;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   out_ok_r;
  logic                   out_ok_nxt;
  logic [ENTRY_WIDTH-1:0] out_read_value_r;
  logic [ENTRY_WIDTH-1:0] out_read_value_nxt;
  logic                   out_now_empty_r;
  logic                   out_now_empty_nxt;

  // Handshake: the input side waits only while a finished result is held.
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // A written length of zero means one, and anything above the cell count
  // is cut down to the cell count.
  assign cfg_ext = CMP_W'(cfg_wr_data);

  always_comb begin
    len_nxt = len_r;
    if (cfg_wr_en) begin
      if (cfg_ext == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_ENTRIES)) begin
        len_nxt = LEN_W'(MAX_ENTRIES);
      end else begin
        len_nxt = LEN_W'(cfg_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(MAX_ENTRIES);
    end else begin
      len_r <= len_nxt;
    end
  end

  // Shift command for the chain. A pop on an empty stack leaves it alone,
  // and a length write empties the stack just as a clear does.
  always_comb begin
    ctrl.push  = in_fire && (in_func == FUNC_PUSH);
    ctrl.pop   = in_fire && (in_func == FUNC_POP) && cell_valid[0];
    ctrl.flush = (in_fire && (in_func == FUNC_CLEAR)) || cfg_wr_en;
  end

  assign valid_ext = {1'b0, cell_valid};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic                   prev_valid;
      logic [ENTRY_WIDTH-1:0] prev_data;
      logic                   next_valid;
      logic [ENTRY_WIDTH-1:0] next_data;

      assign in_ring[gi] = len_r > LEN_W'(gi);

      if (gi == 0) begin : g_head
        assign prev_valid = 1'b1;
        assign prev_data  = in_push_value;
      end else begin : g_body
        assign prev_valid = cell_valid[gi-1];
        assign prev_data  = cell_data[gi-1];
      end

      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign next_valid = 1'b0;
        assign next_data  = '0;
      end else begin : g_link
        assign next_valid = cell_valid[gi+1];
        assign next_data  = cell_data[gi+1];
      end

      ohs_cell #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_ring    (in_ring[gi]),
        .prev_valid (prev_valid),
        .prev_data  (prev_data),
        .next_valid (next_valid),
        .next_data  (next_data),
        .valid      (cell_valid[gi]),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  // The result is formed from the chain head before the shift takes effect.
  // The empty flag after a pop is the valid bit of the cell that moves up.
  always_comb begin
    out_valid_nxt      = in_fire | (out_valid_r & out_stall);
    out_ok_nxt         = out_ok_r;
    out_read_value_nxt = out_read_value_r;
    out_now_empty_nxt  = out_now_empty_r;
    if (in_fire) begin
      out_ok_nxt         = 1'b1;
      out_read_value_nxt = '0;
      out_now_empty_nxt  = ~cell_valid[0];
      case (in_func)
        FUNC_PUSH: begin
          out_now_empty_nxt = 1'b0;
        end
        FUNC_POP: begin
          out_ok_nxt         = cell_valid[0];
          out_read_value_nxt = cell_valid[0] ? cell_data[0] : '0;
          out_now_empty_nxt  = ~valid_ext[1];
        end
        FUNC_PEEK: begin
          out_ok_nxt         = cell_valid[0];
          out_read_value_nxt = cell_valid[0] ? cell_data[0] : '0;
        end
        FUNC_CLEAR: begin
          out_now_empty_nxt = 1'b1;
        end
        default: begin
          out_ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r         <= out_ok_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_now_empty_r  <= out_now_empty_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_now_empty  = out_now_empty_r;

  // The occupied cells always form one solid run starting at the head.
  a_valid_run : assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + MAX_ENTRIES'(1))) == '0)
    else $error("cell valid bits are not a solid run from the head");

  // No cell beyond the ring length ever holds an entry.
  a_within_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & ~in_ring) == '0)
    else $error("entry held beyond the ring length");

  // The ring length stays between one and the cell count.
  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (len_r <= LEN_W'(MAX_ENTRIES)))
    else $error("ring length out of range");

  // A length write leaves the stack empty.
  a_cfg_empties : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (cell_valid == '0))
    else $error("stack not empty after a length write");

  // An accepted pop or peek always yields a result beat on the next cycle, and
  // that result reports whether the head was occupied for a pop or peek.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((in_func == FUNC_POP) || (in_func == FUNC_PEEK))
      |=> out_valid_r && (out_ok_r == $past(cell_valid[0])))
    else $error("pop or peek result missing or wrong status");

endmodule
